[design/rbts_pkg.sv]
// Shared types and constants for the ready-bitmap thread scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rbts_pkg;

  localparam int CMD_W   = 2;
  localparam int TICKS_W = 32;
  localparam int SLOT_W  = 6;
  localparam int MASK_W  = 32;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_CREATE   = 2'd0;
  localparam cmd_t CMD_DELAY    = 2'd1;
  localparam cmd_t CMD_TICK     = 2'd2;
  localparam cmd_t CMD_SCHEDULE = 2'd3;

  typedef struct packed {
    logic accept;
    logic do_create;
    logic do_delay;
    logic tick_start;
    logic tick_step;
    logic do_pick;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic idle_run;
    logic tick_empty;
    logic tick_more;
  } stat_t;

endpackage

`default_nettype wire

[design/rbts_cmd_if.sv]
// Command channel: one scheduler command per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface rbts_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [rbts_pkg::CMD_W-1:0]   command;
  logic [rbts_pkg::TICKS_W-1:0] delay_ticks;

  modport source (output valid, output command, output delay_ticks, input ready);
  modport sink   (input valid, input command, input delay_ticks, output ready);
endinterface

`default_nettype wire

[design/rbts_res_if.sv]
// Result channel: one scheduler result per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface rbts_res_if;
  logic                        valid;
  logic                        ready;
  logic [rbts_pkg::SLOT_W-1:0] next_slot;
  logic                        switch_request;
  logic [rbts_pkg::MASK_W-1:0] ready_mask;
  logic [rbts_pkg::SLOT_W-1:0] assigned_slot;
  logic                        error;

  modport source (output valid, output next_slot, output switch_request,
                  output ready_mask, output assigned_slot, output error, input ready);
  modport sink   (input valid, input next_slot, input switch_request,
                  input ready_mask, input assigned_slot, input error, output ready);
endinterface

`default_nettype wire

[design/rbts_ctrl.sv]
// Scheduler controller: sequences each command and the result handoff.
`timescale 1ns / 1ps
`default_nettype none

module rbts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire rbts_pkg::stat_t stat,
  output rbts_pkg::ctrl_t      ctrl
);
  import rbts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_CREATE: begin
            ctrl.do_create = 1'b1;
            state_next     = S_DONE;
          end
          CMD_DELAY: begin
            ctrl.do_delay = 1'b1;
            state_next    = stat.idle_run ? S_DONE : S_PICK;
          end
          CMD_TICK: begin
            if (stat.tick_empty) begin
              state_next = S_DONE;
            end else begin
              ctrl.tick_start = 1'b1;
              state_next      = S_TICK;
            end
          end
          CMD_SCHEDULE: begin
            state_next = S_PICK;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_TICK: begin
        ctrl.tick_step = 1'b1;
        if (!stat.tick_more) state_next = S_DONE;
      end
      S_PICK: begin
        ctrl.do_pick = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/rbts_dp.sv]
// Scheduler datapath: ready bitmap, slot state, timeout memory and result register.
`timescale 1ns / 1ps
`default_nettype none

module rbts_dp #(
  parameter int THREAD_CAP = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rbts_pkg::ctrl_t               ctrl,
  output rbts_pkg::stat_t                    stat,
  input  wire logic [rbts_pkg::CMD_W-1:0]    command,
  input  wire logic [rbts_pkg::TICKS_W-1:0]  delay_ticks,
  output logic [rbts_pkg::SLOT_W-1:0]        next_slot,
  output logic                               switch_request,
  output logic [rbts_pkg::MASK_W-1:0]        ready_mask,
  output logic [rbts_pkg::SLOT_W-1:0]        assigned_slot,
  output logic                               error
);
  import rbts_pkg::*;

  localparam int CNT_W = $clog2(THREAD_CAP + 2);
  localparam int IDX_W = (THREAD_CAP > 1) ? $clog2(THREAD_CAP) : 1;

  logic [THREAD_CAP-1:0]  ready_bits;
  logic [CNT_W-1:0]       slot_count;
  logic [CNT_W-1:0]       running_slot;
  logic [CNT_W-1:0]       before_slot;
  cmd_t                   cmd;
  logic [TICKS_W-1:0]     ticks;
  logic [CNT_W-1:0]       assigned;
  logic                   err;

  logic [TICKS_W-1:0]     timeouts [THREAD_CAP];
  logic [THREAD_CAP-1:0]  tvalid;
  logic [TICKS_W-1:0]     rd_data;
  logic                   rd_valid;
  logic [IDX_W-1:0]       proc_idx;

  logic [CNT_W-1:0]       walk;
  logic [CNT_W-1:0]       entry_cnt;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [TICKS_W-1:0]     wr_data;
  logic [TICKS_W-1:0]     cur_val;
  logic [TICKS_W-1:0]     dec_val;
  logic [IDX_W-1:0]       run_idx;
  logic [IDX_W-1:0]       new_idx;
  logic [CNT_W-1:0]       run_m1;
  logic [CNT_W-1:0]       cnt_m1;

  logic [THREAD_CAP-1:0]  lowest;
  logic [CNT_W-1:0]       pick_slot;

  assign entry_cnt = (slot_count == '0) ? '0 : slot_count - CNT_W'(1);
  assign run_m1    = running_slot - CNT_W'(1);
  assign cnt_m1    = slot_count - CNT_W'(1);
  assign run_idx   = run_m1[IDX_W-1:0];
  assign new_idx   = cnt_m1[IDX_W-1:0];
  assign rd_addr   = walk[IDX_W-1:0];

  assign stat.cmd        = cmd;
  assign stat.idle_run   = (running_slot == '0);
  assign stat.tick_empty = (entry_cnt == '0);
  assign stat.tick_more  = (walk < entry_cnt);

  assign rd_en   = ctrl.tick_start | (ctrl.tick_step & stat.tick_more);
  assign cur_val = rd_valid ? rd_data : '0;
  assign dec_val = (cur_val != '0) ? cur_val - TICKS_W'(1) : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx;
    wr_data = dec_val;
    if (ctrl.do_delay && running_slot != '0) begin
      wr_en   = 1'b1;
      wr_addr = run_idx;
      wr_data = ticks;
    end else if (ctrl.tick_step) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    lowest    = ready_bits & (~ready_bits + THREAD_CAP'(1));
    pick_slot = '0;
    for (int k = 0; k < THREAD_CAP; k++) begin
      if (lowest[k]) pick_slot = pick_slot | CNT_W'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) timeouts[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data  <= timeouts[rd_addr];
      proc_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid   <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) tvalid[wr_addr] <= 1'b1;
      if (rd_en) rd_valid <= tvalid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_bits   <= '0;
      slot_count   <= '0;
      running_slot <= '0;
    end else begin
      if (ctrl.do_create && slot_count <= CNT_W'(THREAD_CAP)) begin
        if (slot_count != '0) ready_bits[new_idx] <= 1'b1;
        slot_count <= slot_count + CNT_W'(1);
      end
      if (ctrl.do_delay && running_slot != '0) ready_bits[run_idx] <= 1'b0;
      if (ctrl.tick_step && dec_val == '0) ready_bits[proc_idx] <= 1'b1;
      if (ctrl.do_pick) running_slot <= pick_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd         <= command;
      ticks       <= delay_ticks;
      before_slot <= running_slot;
      assigned    <= '0;
      err         <= 1'b0;
      walk        <= '0;
    end
    if (ctrl.do_create) begin
      if (slot_count > CNT_W'(THREAD_CAP)) begin
        err <= 1'b1;
      end else begin
        assigned <= slot_count;
      end
    end
    if (ctrl.do_delay && running_slot == '0) err <= 1'b1;
    if (rd_en) walk <= walk + CNT_W'(1);
    if (ctrl.load_out) begin
      next_slot      <= SLOT_W'(running_slot);
      switch_request <= (running_slot != before_slot);
      ready_mask     <= MASK_W'(ready_bits);
      assigned_slot  <= SLOT_W'(assigned);
      error          <= err;
    end
  end

endmodule

`default_nettype wire

[design/ready_bitmap_thread_scheduler_unit.sv]
// Top level of the ready-bitmap thread scheduler.
`timescale 1ns / 1ps
`default_nettype none

// Thread scheduler with a ready bitmap and per-slot tick timeouts. Slot 0 is
// the idle thread; slots 1..THREAD_CAP are created in order. Each command
// yields one result on the result channel. Create and a delay from idle go
// straight from execution to the result register, delay and schedule pass
// the pick state first, and a tick walks the timeout memory, one entry per
// cycle through its single read port, over every created slot but slot 0.
// The controller then returns to idle to accept the next command.
// The next command transfers as soon as a result sits in the output register.
// No clearing pass is needed after reset.
module ready_bitmap_thread_scheduler_unit #(
  parameter int THREAD_CAP = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  rbts_cmd_if.sink   cmd,
  rbts_res_if.source res
);
  import rbts_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  rbts_dp #(
    .THREAD_CAP (THREAD_CAP)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .stat           (stat),
    .command        (cmd.command),
    .delay_ticks    (cmd.delay_ticks),
    .next_slot      (res.next_slot),
    .switch_request (res.switch_request),
    .ready_mask     (res.ready_mask),
    .assigned_slot  (res.assigned_slot),
    .error          (res.error)
  );

endmodule

`default_nettype wire

[verif/ready_bitmap_thread_scheduler_unit_test.sv]
// Self-checking testbench for the ready-bitmap thread scheduler unit.
`timescale 1ns / 1ps

module ready_bitmap_thread_scheduler_unit_test;
  import rbts_pkg::*;

  localparam int NUM_THREADS = 32;
  localparam int RANDOM_CMDS = 900;
  localparam int IDLE_PCT    = 35;

  typedef struct {
    cmd_t              command;
    logic [TICKS_W-1:0] delay_ticks;
  } sched_cmd_t;

  typedef struct {
    logic [SLOT_W-1:0] next_slot;
    logic              switch_request;
    logic [MASK_W-1:0] ready_mask;
    logic [SLOT_W-1:0] assigned_slot;
    logic              error;
  } sched_result_t;

  logic clk;
  logic rst;

  rbts_cmd_if cmd_ch ();
  rbts_res_if res_ch ();

  ready_bitmap_thread_scheduler_unit #(
    .THREAD_CAP(NUM_THREADS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];
  int            cmds_queued = 0;
  int            cmds_sent;
  int            errors;

  // scheduler state mirror
  logic [MASK_W-1:0]  ready_bits_m;
  int unsigned        slot_count_m;
  int unsigned        running_m;
  logic [TICKS_W-1:0] timeout_m [NUM_THREADS];

  function automatic int unsigned lowest_ready();
    for (int k = 0; k < NUM_THREADS; k++) begin
      if (ready_bits_m[k]) return k + 1;
    end
    return 0;
  endfunction

  function automatic sched_result_t advance_scheduler(cmd_t command, logic [TICKS_W-1:0] ticks);
    sched_result_t r;
    int unsigned   prev_slot;
    int unsigned   idx;
    bit            resched;
    prev_slot       = running_m;
    resched         = 1'b0;
    r.assigned_slot = '0;
    r.error         = 1'b0;
    case (command)
      CMD_CREATE: begin
        if (slot_count_m > NUM_THREADS) begin
          r.error = 1'b1;
        end else begin
          r.assigned_slot = slot_count_m[SLOT_W-1:0];
          if (slot_count_m > 0) ready_bits_m[slot_count_m - 1] = 1'b1;
          slot_count_m++;
        end
      end
      CMD_DELAY: begin
        if (running_m == 0) begin
          r.error = 1'b1;
        end else begin
          idx               = running_m - 1;
          timeout_m[idx]    = ticks;
          ready_bits_m[idx] = 1'b0;
          resched           = 1'b1;
        end
      end
      CMD_TICK: begin
        for (int n = 1; n < slot_count_m && n <= NUM_THREADS; n++) begin
          if (timeout_m[n-1] != 0) timeout_m[n-1] = timeout_m[n-1] - 1;
          if (timeout_m[n-1] == 0) ready_bits_m[n-1] = 1'b1;
        end
      end
      default: begin
        resched = 1'b1;
      end
    endcase
    if (resched) running_m = lowest_ready();
    r.next_slot      = running_m[SLOT_W-1:0];
    r.switch_request = (running_m != prev_slot);
    r.ready_mask     = ready_bits_m;
    return r;
  endfunction

  function automatic bit idle_now();
    if (cmds_sent >= 350 && cmds_sent < 500) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic queue_cmd(cmd_t command, logic [TICKS_W-1:0] ticks);
    sched_cmd_t item;
    item.command     = command;
    item.delay_ticks = ticks;
    pending_cmds.push_back(item);
    cmds_queued++;
  endtask

  function automatic logic [TICKS_W-1:0] random_ticks();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom_range(3);
    if (sel < 90) return $urandom_range(40, 4);
    if (sel < 97) return $urandom_range(300, 41);
    return $urandom();
  endfunction

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_CREATE;
    cmd_ch.delay_ticks = '0;
    res_ch.ready       = 1'b0;
    ready_bits_m       = '0;
    slot_count_m       = 0;
    running_m          = 0;
    cmds_sent          = 0;
    errors             = 0;
    foreach (timeout_m[i]) timeout_m[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // command driver
  always @(posedge clk) begin : drive_cmds
    sched_cmd_t item;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_results.push_back(advance_scheduler(cmd_ch.command, cmd_ch.delay_ticks));
        cmds_sent++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() > 0 && !idle_now()) begin
          item                = pending_cmds.pop_front();
          cmd_ch.valid       <= 1'b1;
          cmd_ch.command     <= item.command;
          cmd_ch.delay_ticks <= item.delay_ticks;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    sched_result_t exp_r;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual slot %0d mask %0h",
                   $time, res_ch.next_slot, res_ch.ready_mask);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("next_slot", 32'(exp_r.next_slot), 32'(res_ch.next_slot));
          check_field("switch_request", 32'(exp_r.switch_request),
                      32'(res_ch.switch_request));
          check_field("ready_mask", exp_r.ready_mask, res_ch.ready_mask);
          check_field("assigned_slot", 32'(exp_r.assigned_slot),
                      32'(res_ch.assigned_slot));
          check_field("error", 32'(exp_r.error), 32'(res_ch.error));
        end
      end
      res_ch.ready <= !idle_now();
    end
  end

  initial begin : stimulus
    int unsigned sel;
    queue_cmd(CMD_CREATE, '0);
    queue_cmd(CMD_DELAY, 32'd5);
    queue_cmd(CMD_SCHEDULE, '0);
    queue_cmd(CMD_TICK, '1);
    queue_cmd(CMD_CREATE, '1);
    queue_cmd(CMD_CREATE, '0);
    queue_cmd(CMD_CREATE, '0);
    queue_cmd(CMD_SCHEDULE, '0);
    queue_cmd(CMD_DELAY, '0);
    queue_cmd(CMD_DELAY, 32'd1);
    queue_cmd(CMD_DELAY, '1);
    queue_cmd(CMD_TICK, '0);
    queue_cmd(CMD_SCHEDULE, '0);
    queue_cmd(CMD_DELAY, 32'd2);
    queue_cmd(CMD_TICK, '0);
    queue_cmd(CMD_TICK, '0);
    queue_cmd(CMD_SCHEDULE, '0);
    queue_cmd(CMD_CREATE, '0);
    queue_cmd(CMD_CREATE, '0);
    queue_cmd(CMD_DELAY, 32'd3);
    queue_cmd(CMD_SCHEDULE, 32'hAAAA_5555);
    queue_cmd(CMD_TICK, '0);
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      sel = $urandom_range(99);
      if (sel < 10) queue_cmd(CMD_CREATE, $urandom());
      else if (sel < 40) queue_cmd(CMD_DELAY, random_ticks());
      else if (sel < 70) queue_cmd(CMD_TICK, $urandom());
      else queue_cmd(CMD_SCHEDULE, $urandom());
    end
    wait (cmds_sent == cmds_queued);
    wait (expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
